@@ src/kld_pkg.sv @@
// kld_pkg: state codes, token kinds, keyword ids and DFA transition functions
// for the keyword lexer. No dependencies.
package kld_pkg;

   localparam int STATE_W = 6;

   localparam logic [STATE_W-1:0] ST_START  = 6'd0;
   localparam logic [STATE_W-1:0] ST_INT    = 6'd1;
   localparam logic [STATE_W-1:0] ST_ZERO   = 6'd2;
   localparam logic [STATE_W-1:0] ST_I      = 6'd3;
   localparam logic [STATE_W-1:0] ST_IN     = 6'd4;
   localparam logic [STATE_W-1:0] ST_INT_KW = 6'd5;
   localparam logic [STATE_W-1:0] ST_IDENT  = 6'd6;
   localparam logic [STATE_W-1:0] ST_OP     = 6'd7;
   localparam logic [STATE_W-1:0] ST_F      = 6'd8;
   localparam logic [STATE_W-1:0] ST_FO     = 6'd9;
   localparam logic [STATE_W-1:0] ST_FOR    = 6'd10;
   localparam logic [STATE_W-1:0] ST_R      = 6'd11;
   localparam logic [STATE_W-1:0] ST_RE     = 6'd12;
   localparam logic [STATE_W-1:0] ST_REA    = 6'd13;
   localparam logic [STATE_W-1:0] ST_READ   = 6'd14;
   localparam logic [STATE_W-1:0] ST_P      = 6'd15;
   localparam logic [STATE_W-1:0] ST_PR     = 6'd16;
   localparam logic [STATE_W-1:0] ST_PRI    = 6'd17;
   localparam logic [STATE_W-1:0] ST_PRIN   = 6'd18;
   localparam logic [STATE_W-1:0] ST_PRINT  = 6'd19;
   localparam logic [STATE_W-1:0] ST_IF     = 6'd20;
   localparam logic [STATE_W-1:0] ST_E      = 6'd21;
   localparam logic [STATE_W-1:0] ST_EL     = 6'd22;
   localparam logic [STATE_W-1:0] ST_ELS    = 6'd23;
   localparam logic [STATE_W-1:0] ST_ELSE   = 6'd24;
   localparam logic [STATE_W-1:0] ST_W      = 6'd25;
   localparam logic [STATE_W-1:0] ST_WH     = 6'd26;
   localparam logic [STATE_W-1:0] ST_WHI    = 6'd27;
   localparam logic [STATE_W-1:0] ST_WHIL   = 6'd28;
   localparam logic [STATE_W-1:0] ST_WHILE  = 6'd29;
   localparam logic [STATE_W-1:0] ST_EN     = 6'd30;
   localparam logic [STATE_W-1:0] ST_END    = 6'd31;
   localparam logic [STATE_W-1:0] ST_ASSIGN = 6'd32;
   localparam logic [STATE_W-1:0] ST_EQ     = 6'd33;
   localparam logic [STATE_W-1:0] ST_BANG   = 6'd34;
   localparam logic [STATE_W-1:0] ST_NE     = 6'd35;
   localparam logic [STATE_W-1:0] ST_GT     = 6'd36;
   localparam logic [STATE_W-1:0] ST_GE     = 6'd37;
   localparam logic [STATE_W-1:0] ST_LT     = 6'd38;
   localparam logic [STATE_W-1:0] ST_LE     = 6'd39;

   localparam logic [3:0] K_INT     = 4'd0;
   localparam logic [3:0] K_OP      = 4'd1;
   localparam logic [3:0] K_ASSIGN  = 4'd2;
   localparam logic [3:0] K_CMP     = 4'd3;
   localparam logic [3:0] K_KEYWORD = 4'd4;
   localparam logic [3:0] K_IDENT   = 4'd5;
   localparam logic [3:0] K_EOL     = 4'd6;
   localparam logic [3:0] K_END     = 4'd7;
   localparam logic [3:0] K_LBRACE  = 4'd8;
   localparam logic [3:0] K_RBRACE  = 4'd9;
   localparam logic [3:0] K_LPAREN  = 4'd10;
   localparam logic [3:0] K_RPAREN  = 4'd11;
   localparam logic [3:0] K_COMMA   = 4'd12;
   localparam logic [3:0] K_BAD     = 4'd13;

   localparam logic [2:0] KW_READ  = 3'd0;
   localparam logic [2:0] KW_PRINT = 3'd1;
   localparam logic [2:0] KW_IF    = 3'd2;
   localparam logic [2:0] KW_INT   = 3'd3;
   localparam logic [2:0] KW_FOR   = 3'd4;
   localparam logic [2:0] KW_WHILE = 3'd5;
   localparam logic [2:0] KW_ELSE  = 3'd6;
   localparam logic [2:0] KW_NONE  = 3'd7;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SPACE = " ";

   typedef struct packed {
      logic       load;
      logic [1:0] count;
   } load_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || is_digit(c) || (c == "_") || (c == "@")
             || (c == "#") || (c == "$");
   endfunction

   // ST_START doubles as "no transition": no edge leads back to the start state
   function automatic logic [STATE_W-1:0] next_state(input logic [STATE_W-1:0] s,
                                                     input logic [7:0] c);
      logic [STATE_W-1:0] nx;
      logic               chain;
      nx    = ST_START;
      chain = 1'b0;
      case (s)
         ST_START: begin
            if ((c >= "1") && (c <= "9"))                            nx = ST_INT;
            else if (c == "0")                                       nx = ST_ZERO;
            else if ((c == "+") || (c == "-") || (c == "/") || (c == "*")) nx = ST_OP;
            else if (c == "=")                                       nx = ST_ASSIGN;
            else if (c == "!")                                       nx = ST_BANG;
            else if (c == ">")                                       nx = ST_GT;
            else if (c == "<")                                       nx = ST_LT;
            else if (c == "e")                                       nx = ST_E;
            else if (c == "w")                                       nx = ST_W;
            else if (c == "r")                                       nx = ST_R;
            else if (c == "i")                                       nx = ST_I;
            else if (c == "f")                                       nx = ST_F;
            else if (c == "p")                                       nx = ST_P;
            else if (is_word(c) && !is_digit(c))                     nx = ST_IDENT;
         end
         ST_INT:    nx = is_digit(c) ? ST_INT : ST_START;
         ST_ASSIGN: nx = (c == "=") ? ST_EQ : ST_START;
         ST_BANG:   nx = (c == "=") ? ST_NE : ST_START;
         ST_GT:     nx = (c == "=") ? ST_GE : ST_START;
         ST_LT:     nx = (c == "=") ? ST_LE : ST_START;
         ST_I: begin
            chain = 1'b1;
            if (c == "f")      nx = ST_IF;
            else if (c == "n") nx = ST_IN;
         end
         ST_IN:   begin chain = 1'b1; if (c == "t") nx = ST_INT_KW; end
         ST_F:    begin chain = 1'b1; if (c == "o") nx = ST_FO; end
         ST_FO:   begin chain = 1'b1; if (c == "r") nx = ST_FOR; end
         ST_R:    begin chain = 1'b1; if (c == "e") nx = ST_RE; end
         ST_RE:   begin chain = 1'b1; if (c == "a") nx = ST_REA; end
         ST_REA:  begin chain = 1'b1; if (c == "d") nx = ST_READ; end
         ST_P:    begin chain = 1'b1; if (c == "r") nx = ST_PR; end
         ST_PR:   begin chain = 1'b1; if (c == "i") nx = ST_PRI; end
         ST_PRI:  begin chain = 1'b1; if (c == "n") nx = ST_PRIN; end
         ST_PRIN: begin chain = 1'b1; if (c == "t") nx = ST_PRINT; end
         ST_E: begin
            chain = 1'b1;
            if (c == "l")      nx = ST_EL;
            else if (c == "n") nx = ST_EN;
         end
         ST_EL:   begin chain = 1'b1; if (c == "s") nx = ST_ELS; end
         ST_ELS:  begin chain = 1'b1; if (c == "e") nx = ST_ELSE; end
         ST_W:    begin chain = 1'b1; if (c == "h") nx = ST_WH; end
         ST_WH:   begin chain = 1'b1; if (c == "i") nx = ST_WHI; end
         ST_WHI:  begin chain = 1'b1; if (c == "l") nx = ST_WHIL; end
         ST_WHIL: begin chain = 1'b1; if (c == "e") nx = ST_WHILE; end
         ST_EN:   begin chain = 1'b1; if (c == "d") nx = ST_END; end
         ST_INT_KW, ST_IDENT, ST_FOR, ST_READ, ST_PRINT, ST_IF, ST_ELSE, ST_WHILE,
         ST_END:  chain = 1'b1;
         default: nx = ST_START;
      endcase
      if (chain && (nx == ST_START) && is_word(c)) nx = ST_IDENT;
      return nx;
   endfunction

   function automatic logic [3:0] token_kind(input logic [STATE_W-1:0] s);
      logic [3:0] k;
      case (s)
         ST_INT, ST_ZERO:                           k = K_INT;
         ST_OP:                                     k = K_OP;
         ST_ASSIGN:                                 k = K_ASSIGN;
         ST_EQ, ST_NE, ST_GT, ST_GE, ST_LT, ST_LE:  k = K_CMP;
         ST_READ, ST_PRINT, ST_IF, ST_INT_KW, ST_FOR, ST_WHILE, ST_ELSE: k = K_KEYWORD;
         default:                                   k = K_IDENT;
      endcase
      return k;
   endfunction

   function automatic logic [2:0] token_kw(input logic [STATE_W-1:0] s);
      logic [2:0] kw;
      case (s)
         ST_READ:   kw = KW_READ;
         ST_PRINT:  kw = KW_PRINT;
         ST_IF:     kw = KW_IF;
         ST_INT_KW: kw = KW_INT;
         ST_FOR:    kw = KW_FOR;
         ST_WHILE:  kw = KW_WHILE;
         ST_ELSE:   kw = KW_ELSE;
         default:   kw = KW_NONE;
      endcase
      return kw;
   endfunction

endpackage

@@ src/keyword_lexer_dfa.sv @@
// keyword_lexer_dfa: top level of the keyword lexer; joins the DFA step and the
// result buffer. Uses kld_pkg, kld_step and kld_rsp_buf.
//
// One source byte enters per req_ beat (NUL ends the input). Each byte gives
// zero to three token beats on rsp_; rsp_tlast marks the final token of a byte.
// Throughput: one byte per cycle while each byte yields at most one token and
// rsp_tready stays high; a byte that yields several tokens holds the input side
// while the result register drains them, one per cycle while rsp_tready is high.
// A byte sits in the input register; the step logic writes its tokens into the
// three-slot result register once that register is empty or giving up its last
// token, so a stalled rsp_ side backs up into req_tready after two bytes with tokens.
// After a bad token or program end the lexer is halted: bytes are still taken,
// but give no tokens until reset.
// Reset (synchronous) returns the DFA to its start state, clears the position
// and length counters, the newline flag and the halt, and drops buffered beats.
module keyword_lexer_dfa #(
   parameter int POS_WIDTH = 32,
   parameter int LEN_MAX   = 255,
   localparam int LEN_W    = $clog2(LEN_MAX + 1),
   localparam int RES_W    = 7 + LEN_W + POS_WIDTH,
   localparam int TDATA_W  = ((RES_W + 7) / 8) * 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // ch[7:0]
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // kind[4], keyword_id[3], token_length, token_start
   output logic               rsp_tlast    // last
);

   kld_pkg::load_type     ld;
   logic [2:0][RES_W-1:0] res;
   logic                  load_ok;
   logic [RES_W-1:0]      rsp_res;

   kld_step #(
      .POS_WIDTH (POS_WIDTH),
      .LEN_MAX   (LEN_MAX),
      .LEN_W     (LEN_W),
      .RES_W     (RES_W)
   ) u_step (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .load_ok    (load_ok),
      .ld         (ld),
      .res        (res)
   );

   kld_rsp_buf #(
      .RES_W (RES_W)
   ) u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .ld         (ld),
      .res        (res),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tdata = TDATA_W'(rsp_res);

endmodule

@@ src/kld_step.sv @@
// kld_step: input character register, lexer state registers and the one-pass
// DFA step that yields up to three tokens per character. Uses kld_pkg.
module kld_step #(
   parameter int POS_WIDTH = 32,
   parameter int LEN_MAX   = 255,
   parameter int LEN_W     = 8,
   parameter int RES_W     = 7 + LEN_W + POS_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 load_ok,
   output kld_pkg::load_type    ld,
   output logic [2:0][RES_W-1:0] res
);

   logic [7:0]                   ch_ff;
   logic                         in_vld_ff;
   logic [kld_pkg::STATE_W-1:0]  state_ff, state_in;
   logic [LEN_W-1:0]             len_ff, len_in;
   logic [POS_WIDTH-1:0]         start_ff, start_in;
   logic [POS_WIDTH-1:0]         pos_ff, pos_in;
   logic                         prev_ff, prev_in;
   logic                         halted_ff, halted_in;
   logic [1:0]                   n;
   logic                         fire;
   logic [kld_pkg::STATE_W-1:0]  nx;
   logic                         done;

   function automatic logic [RES_W-1:0] pack_res(input logic [3:0] kind,
                                                 input logic [2:0] kw,
                                                 input logic [LEN_W-1:0] len,
                                                 input logic [POS_WIDTH-1:0] start);
      return {start, len, kw, kind};
   endfunction

   always_comb begin
      state_in  = state_ff;
      len_in    = len_ff;
      start_in  = start_ff;
      pos_in    = pos_ff;
      prev_in   = prev_ff;
      halted_in = halted_ff;
      res       = '0;
      n         = 2'd0;
      nx        = kld_pkg::ST_START;
      done      = 1'b0;
      if (!halted_ff) begin
         pos_in = pos_ff + 1'b1;
         if (state_ff != kld_pkg::ST_START) begin
            nx = kld_pkg::next_state(state_ff, ch_ff);
            if (nx != kld_pkg::ST_START) begin
               state_in = nx;
               if (len_ff != LEN_W'(LEN_MAX)) len_in = len_ff + 1'b1;
               done = 1'b1;
            end else if (state_ff == kld_pkg::ST_END) begin
               res[0] = pack_res(kld_pkg::K_EOL, kld_pkg::KW_NONE, '0, start_ff);
               res[1] = pack_res(kld_pkg::K_END, kld_pkg::KW_NONE, len_ff, start_ff);
               n = 2'd2;
               halted_in = 1'b1;
               state_in = kld_pkg::ST_START;
               done = 1'b1;
            end else if (state_ff == kld_pkg::ST_BANG) begin
               res[0] = pack_res(kld_pkg::K_BAD, kld_pkg::KW_NONE, len_ff, start_ff);
               n = 2'd1;
               halted_in = 1'b1;
               state_in = kld_pkg::ST_START;
               done = 1'b1;
            end else begin
               res[0] = pack_res(kld_pkg::token_kind(state_ff), kld_pkg::token_kw(state_ff),
                                 len_ff, start_ff);
               n = 2'd1;
               prev_in = 1'b0;
               state_in = kld_pkg::ST_START;
            end
         end
         if (!done) begin
            case (ch_ff)
               kld_pkg::CH_SPACE: ;
               kld_pkg::CH_NL: begin
                  if (!prev_in) begin
                     res[n] = pack_res(kld_pkg::K_EOL, kld_pkg::KW_NONE, LEN_W'(1), pos_ff);
                     n = n + 2'd1;
                  end
                  prev_in = 1'b1;
               end
               kld_pkg::CH_NUL: begin
                  res[n] = pack_res(kld_pkg::K_EOL, kld_pkg::KW_NONE, '0, pos_ff);
                  res[n + 2'd1] = pack_res(kld_pkg::K_END, kld_pkg::KW_NONE, LEN_W'(1), pos_ff);
                  n = n + 2'd2;
                  halted_in = 1'b1;
               end
               "{", "}", "(", ")", ",": begin
                  res[n] = pack_res((ch_ff == "{") ? kld_pkg::K_LBRACE :
                                    (ch_ff == "}") ? kld_pkg::K_RBRACE :
                                    (ch_ff == "(") ? kld_pkg::K_LPAREN :
                                    (ch_ff == ")") ? kld_pkg::K_RPAREN : kld_pkg::K_COMMA,
                                    kld_pkg::KW_NONE, LEN_W'(1), pos_ff);
                  n = n + 2'd1;
                  prev_in = 1'b0;
               end
               default: begin
                  nx = kld_pkg::next_state(kld_pkg::ST_START, ch_ff);
                  if (nx == kld_pkg::ST_START) begin
                     res[n] = pack_res(kld_pkg::K_BAD, kld_pkg::KW_NONE, LEN_W'(1), pos_ff);
                     n = n + 2'd1;
                     halted_in = 1'b1;
                  end else begin
                     state_in = nx;
                     len_in   = LEN_W'(1);
                     start_in = pos_ff;
                  end
               end
            endcase
         end
      end
   end

   assign fire       = in_vld_ff && ((n == 2'd0) || load_ok);
   assign req_tready = !in_vld_ff || fire;
   assign ld         = {fire && (n != 2'd0), n};

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         ch_ff <= req_tdata;
      end
      if (reset) begin
         in_vld_ff <= 1'b0;
         state_ff  <= kld_pkg::ST_START;
         len_ff    <= '0;
         start_ff  <= '0;
         pos_ff    <= '0;
         prev_ff   <= 1'b0;
         halted_ff <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) in_vld_ff <= 1'b1;
         else if (fire)                in_vld_ff <= 1'b0;
         if (fire) begin
            state_ff  <= state_in;
            len_ff    <= len_in;
            start_ff  <= start_in;
            pos_ff    <= pos_in;
            prev_ff   <= prev_in;
            halted_ff <= halted_in;
         end
      end
   end

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !ld.load)
      else $error("tokens produced after halt");
   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(pos_ff))
      else $error("position moved without a consumed character");
   a_halt_start: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> (state_ff == kld_pkg::ST_START))
      else $error("halted with a token in progress");

endmodule

@@ src/kld_rsp_buf.sv @@
// kld_rsp_buf: three-slot result register that serialises the tokens of one
// character onto the result channel. Uses kld_pkg.
module kld_rsp_buf #(
   parameter int RES_W = 47
) (
   input  logic                  clock,
   input  logic                  reset,
   input  kld_pkg::load_type     ld,
   input  logic [2:0][RES_W-1:0] res,
   output logic                  load_ok,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RES_W-1:0]      rsp_res,
   output logic                  rsp_tlast
);

   logic [2:0][RES_W-1:0] slot_ff;
   logic [1:0]            count_ff;
   logic                  pop;

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_res    = slot_ff[0];
   assign rsp_tlast  = (count_ff == 2'd1);
   assign pop        = rsp_tvalid && rsp_tready;
   assign load_ok    = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_tready);

   always_ff @(posedge clock) begin
      if (ld.load) begin
         slot_ff <= res;
      end else if (pop) begin
         slot_ff[0] <= slot_ff[1];
         slot_ff[1] <= slot_ff[2];
      end
      if (reset) begin
         count_ff <= 2'd0;
      end else if (ld.load) begin
         count_ff <= ld.count;
      end else if (pop) begin
         count_ff <= count_ff - 2'd1;
      end
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      ld.load |-> ((count_ff == 2'd0) || ((count_ff == 2'd1) && pop)))
      else $error("results overwritten before delivery");
   a_load_count: assert property (@(posedge clock) disable iff (reset)
      ld.load |-> (ld.count != 2'd0))
      else $error("empty load");
   a_keep_rest: assert property (@(posedge clock) disable iff (reset)
      (pop && (count_ff > 2'd1)) |=> rsp_tvalid)
      else $error("pending results lost");

endmodule
